// ----- rtl/tcce_pkg.sv -----
// Shared types and constants for the text console character engine.
// No dependencies; imported by tcce_ctrl, tcce_dp and the top level.
`timescale 1ns / 1ps

package tcce_pkg;

   localparam int MAX_COLS   = 80;
   localparam int MAX_ROWS   = 25;
   localparam int NCELLS     = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W     = $clog2(NCELLS);
   localparam int LIN_W      = ADDR_W + 1;
   localparam int COL_W      = 7;
   localparam int ROW_W      = 5;
   localparam int CNT_W      = 16;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [1:0] REQ_PUT   = 2'd0;
   localparam logic [1:0] REQ_CLEAR = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOUR  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR  = 2'd3;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [7:0] RESET_ATTR = 8'h07;
   localparam logic [6:0] RESET_COLS = 7'd80;
   localparam logic [4:0] RESET_ROWS = 5'd25;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_ACCEPT,
      DP_NEWLINE,
      DP_SCR_START,
      DP_SCR_RD,
      DP_SCR_WR,
      DP_BLANK,
      DP_SCR_END,
      DP_PUT,
      DP_BS,
      DP_CLR,
      DP_CLR_END,
      DP_INIT,
      DP_READ,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       at_wrap;
      logic       last_row;
      logic       is_lf;
      logic       is_skip;
      logic       is_bs;
      logic       at_home;
      logic       copy_last;
      logic       blank_last;
      logic       store_last;
      logic       out_free;
      logic       tab_more;
   } dp_stat_type;

endpackage

// ----- rtl/tcce_ctrl.sv -----
// Sequencer for the console engine: request dispatch, scroll and clear walks.
// Depends on tcce_pkg; drives tcce_dp through command/status structs.
`timescale 1ns / 1ps

module tcce_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  tcce_pkg::dp_stat_type stat,
   output tcce_pkg::dp_cmd_type  cmd
);
   import tcce_pkg::*;

   typedef enum logic [12:0] {
      S_INIT     = 13'b0000000000001,
      S_IDLE     = 13'b0000000000010,
      S_DISPATCH = 13'b0000000000100,
      S_WRAP     = 13'b0000000001000,
      S_CHAR     = 13'b0000000010000,
      S_SCR_RD   = 13'b0000000100000,
      S_SCR_WR   = 13'b0000001000000,
      S_SCR_BLK  = 13'b0000010000000,
      S_SCR_END  = 13'b0000100000000,
      S_CLR      = 13'b0001000000000,
      S_CLR_END  = 13'b0010000000000,
      S_READ     = 13'b0100000000000,
      S_EMIT     = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      ret_emit_ff, ret_emit_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      ret_emit_in = ret_emit_ff;
      cmd.op      = DP_NOP;
      case (state_ff)
         S_INIT: begin
            cmd.op = DP_INIT;
            if (stat.store_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = DP_ACCEPT;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.req_type)
               REQ_PUT:   state_in = S_WRAP;
               REQ_CLEAR: state_in = S_CLR;
               REQ_READ:  state_in = S_READ;
               default:   state_in = S_EMIT;
            endcase
         end
         S_WRAP: begin
            state_in = S_CHAR;
            if (stat.at_wrap) begin
               if (stat.last_row) begin
                  cmd.op      = DP_SCR_START;
                  ret_emit_in = 1'b0;
                  state_in    = S_SCR_RD;
               end else begin
                  cmd.op = DP_NEWLINE;
               end
            end
         end
         S_CHAR: begin
            state_in = S_EMIT;
            if (stat.is_lf) begin
               if (stat.last_row) begin
                  cmd.op      = DP_SCR_START;
                  ret_emit_in = 1'b1;
                  state_in    = S_SCR_RD;
               end else begin
                  cmd.op = DP_NEWLINE;
               end
            end else if (stat.is_skip) begin
               cmd.op = DP_NOP;
            end else if (stat.is_bs) begin
               if (!stat.at_home) cmd.op = DP_BS;
            end else begin
               cmd.op = DP_PUT;
            end
         end
         S_SCR_RD: begin
            cmd.op   = DP_SCR_RD;
            state_in = S_SCR_WR;
         end
         S_SCR_WR: begin
            cmd.op   = DP_SCR_WR;
            state_in = stat.copy_last ? S_SCR_BLK : S_SCR_RD;
         end
         S_SCR_BLK: begin
            cmd.op = DP_BLANK;
            if (stat.blank_last) state_in = S_SCR_END;
         end
         S_SCR_END: begin
            cmd.op   = DP_SCR_END;
            state_in = ret_emit_ff ? S_EMIT : S_CHAR;
         end
         S_CLR: begin
            cmd.op = DP_CLR;
            if (stat.store_last) state_in = S_CLR_END;
         end
         S_CLR_END: begin
            cmd.op   = DP_CLR_END;
            state_in = S_EMIT;
         end
         S_READ: begin
            cmd.op   = DP_READ;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.op   = DP_EMIT;
               state_in = stat.tab_more ? S_WRAP : S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_INIT;
         ret_emit_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ret_emit_ff <= ret_emit_in;
      end
   end

endmodule

// ----- rtl/tcce_dp.sv -----
// Datapath: config registers, cursor and scroll counter, cell store, result register.
// Depends on tcce_pkg; commanded by tcce_ctrl.
`timescale 1ns / 1ps

module tcce_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  tcce_pkg::dp_cmd_type                cmd,
   output tcce_pkg::dp_stat_type               stat,
   input  logic [1:0]                          req_tuser,
   input  logic [tcce_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tcce_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [tcce_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tcce_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tcce_pkg::*;

   logic [15:0] mem [NCELLS];
   logic [15:0] rdata_ff;

   logic [COL_W-1:0] columns_ff;
   logic [ROW_W-1:0] rows_ff;
   logic [7:0]       colour_ff;
   logic             cursor_en_ff;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   logic              moved_ff, moved_in;
   logic [1:0]        tab_cnt_ff, tab_cnt_in;
   logic [1:0]        type_ff;
   logic [7:0]        chr_ff;
   logic [ADDR_W-1:0] idx_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;

   logic [COL_W-1:0]  nc;
   logic [ROW_W-1:0]  nr;
   logic [ROW_W-1:0]  nr_m1;
   logic [LIN_W-1:0]  cur_lin;
   logic [LIN_W-1:0]  copy_len;
   logic [LIN_W-1:0]  total_len;
   logic [7:0]        chr_eff;
   logic [15:0]       blank;
   logic              is_tab;
   logic              read_hit;
   logic              we;
   logic [ADDR_W-1:0] waddr;
   logic [15:0]       wdata;
   logic              re;
   logic [ADDR_W-1:0] raddr;
   logic [7:0]        cell_char;
   logic [7:0]        cell_attr;

   always_comb begin
      if (columns_ff == '0) nc = COL_W'(1);
      else if (columns_ff > COL_W'(MAX_COLS)) nc = COL_W'(MAX_COLS);
      else nc = columns_ff;
      if (rows_ff < ROW_W'(2)) nr = ROW_W'(2);
      else if (rows_ff > ROW_W'(MAX_ROWS)) nr = ROW_W'(MAX_ROWS);
      else nr = rows_ff;
   end

   assign nr_m1     = nr - ROW_W'(1);
   assign cur_lin   = LIN_W'({7'd0, row_ff} * {5'd0, nc}) + LIN_W'(col_ff);
   assign copy_len  = LIN_W'({7'd0, nr_m1} * {5'd0, nc});
   assign total_len = LIN_W'({7'd0, nr} * {5'd0, nc});
   assign is_tab    = (chr_ff == CH_TAB);
   assign chr_eff   = is_tab ? CH_SPACE : chr_ff;
   assign blank     = {colour_ff, CH_SPACE};
   assign read_hit  = (type_ff == REQ_READ) && (idx_ff < ADDR_W'(NCELLS));

   always_comb begin
      stat.req_type   = type_ff;
      stat.at_wrap    = (col_ff >= nc);
      stat.last_row   = (row_ff >= nr_m1);
      stat.is_lf      = (chr_eff == CH_LF);
      stat.is_skip    = (chr_eff == CH_NUL) || (chr_eff == CH_CR);
      stat.is_bs      = (chr_eff == CH_BS);
      stat.at_home    = (col_ff == '0) && (row_ff == '0);
      stat.copy_last  = ({1'b0, k_ff} == copy_len - LIN_W'(1));
      stat.blank_last = ({1'b0, k_ff} == total_len - LIN_W'(1));
      stat.store_last = (k_ff == ADDR_W'(NCELLS - 1));
      stat.out_free   = !rsp_valid_ff || rsp_tready;
      stat.tab_more   = (type_ff == REQ_PUT) && is_tab && (tab_cnt_ff != 2'd3);
   end

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      moved_in     = moved_ff;
      tab_cnt_in   = tab_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      we           = 1'b0;
      waddr        = k_ff;
      wdata        = blank;
      re           = 1'b0;
      raddr        = idx_ff;
      case (cmd.op)
         DP_ACCEPT: begin
            col_in     = (col_ff > nc) ? nc : col_ff;
            row_in     = (row_ff > nr_m1) ? nr_m1 : row_ff;
            k_in       = '0;
            moved_in   = 1'b0;
            tab_cnt_in = '0;
         end
         DP_NEWLINE: begin
            col_in   = '0;
            row_in   = row_ff + ROW_W'(1);
            moved_in = 1'b1;
         end
         DP_SCR_START: begin
            k_in     = '0;
            moved_in = 1'b1;
         end
         DP_SCR_RD: begin
            re    = 1'b1;
            raddr = ADDR_W'({1'b0, k_ff} + LIN_W'(nc));
         end
         DP_SCR_WR: begin
            we    = 1'b1;
            wdata = rdata_ff;
            k_in  = k_ff + ADDR_W'(1);
         end
         DP_BLANK, DP_CLR: begin
            we   = 1'b1;
            k_in = k_ff + ADDR_W'(1);
         end
         DP_SCR_END: begin
            col_in   = '0;
            row_in   = nr_m1;
            count_in = count_ff + CNT_W'(1);
         end
         DP_PUT: begin
            we       = 1'b1;
            waddr    = cur_lin[ADDR_W-1:0];
            wdata    = {colour_ff, chr_eff};
            col_in   = col_ff + COL_W'(1);
            moved_in = 1'b1;
         end
         DP_BS: begin
            we       = 1'b1;
            waddr    = ADDR_W'(cur_lin - LIN_W'(1));
            moved_in = 1'b1;
            if (col_ff == '0) begin
               row_in = row_ff - ROW_W'(1);
               col_in = nc - COL_W'(1);
            end else begin
               col_in = col_ff - COL_W'(1);
            end
         end
         DP_CLR_END: begin
            col_in   = '0;
            row_in   = '0;
            count_in = '0;
            moved_in = 1'b1;
         end
         DP_INIT: begin
            we    = 1'b1;
            wdata = {RESET_ATTR, CH_SPACE};
            k_in  = (k_ff == ADDR_W'(NCELLS - 1)) ? '0 : k_ff + ADDR_W'(1);
         end
         DP_READ: begin
            re = read_hit;
         end
         DP_EMIT: begin
            rsp_valid_in = 1'b1;
            tab_cnt_in   = tab_cnt_ff + 2'd1;
            moved_in     = 1'b0;
         end
         default: ;
      endcase
   end

   assign cell_char = read_hit ? rdata_ff[7:0]  : 8'd0;
   assign cell_attr = read_hit ? rdata_ff[15:8] : 8'd0;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff   <= RESET_COLS;
         rows_ff      <= RESET_ROWS;
         colour_ff    <= RESET_ATTR;
         cursor_en_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COLUMNS: columns_ff   <= csr_wdata[COL_W-1:0];
            CSR_ROWS:    rows_ff      <= csr_wdata[ROW_W-1:0];
            CSR_COLOUR:  colour_ff    <= csr_wdata;
            CSR_CURSOR:  cursor_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         count_ff     <= '0;
         k_ff         <= '0;
         moved_ff     <= 1'b0;
         tab_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         moved_ff     <= moved_in;
         tab_cnt_ff   <= tab_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_ACCEPT) begin
         type_ff <= req_tuser;
         chr_ff  <= req_tdata[7:0];
         idx_ff  <= req_tdata[8 +: ADDR_W];
      end
      if (cmd.op == DP_EMIT) begin
         rsp_data_ff <= {cell_attr, cell_char, count_ff,
                         moved_ff && cursor_en_ff,
                         cur_lin[ADDR_W-1:0], row_ff, col_ff};
         rsp_last_ff <= !stat.tab_more;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/text_console_character_engine_core.sv -----
// Text console character engine, top level: sequencer plus datapath.
// A scroll copies the rows up by read-then-write over one cell port, then blanks the last row.
// Clear writes the whole cell store, one cell per cycle; a tab gives four results.
// One request at a time: the next transfer is accepted once the last result of a request has loaded.
// Synchronous reset; afterwards a fill of the whole cell store holds req_tready low.
`timescale 1ns / 1ps

module text_console_character_engine_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tcce_pkg::REQ_DATA_W-1:0]     req_tdata,  // char_code[7:0], cell_index[18:8]
   input  logic [1:0]                          req_tuser,  // req_type[1:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tcce_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // cursor_col[6:0], cursor_row[11:7],
                                                           // cursor_index[22:12], cursor_write[23],
                                                           // line_count[39:24], cell_char[47:40],
                                                           // cell_attr[55:48]
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [tcce_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tcce_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tcce_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   tcce_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tcce_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

// ----- dv/tcce_console_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the text console engine: mirrors cell store, cursor, scroll count and registers
// from the observed request, register and result transfers. Depends on tcce_pkg.

module tcce_console_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [tcce_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [1:0]                       req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [tcce_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [tcce_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcce_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               mismatches,
   output int                               outstanding,
   output int                               requests_seen,
   output int                               results_seen,
   output int                               scrolls_seen
);
   import tcce_pkg::*;

   typedef struct packed {
      logic        last;
      logic [7:0]  attr;
      logic [7:0]  chr;
      logic [15:0] lines;
      logic        wr;
      logic [10:0] idx;
      logic [4:0]  row;
      logic [6:0]  col;
   } console_rsp_type;

   logic [15:0]     cells [NCELLS];
   int unsigned     col_q;
   int unsigned     row_q;
   logic [15:0]     scrolls;
   logic [6:0]      reg_cols;
   logic [4:0]      reg_rows;
   logic [7:0]      reg_colour;
   logic            reg_cursor;
   console_rsp_type cursor_results [$];
   console_rsp_type got;
   console_rsp_type want;
   int              n_fail;
   int              n_req;
   int              n_rsp;
   int              n_scroll;

   function automatic int unsigned span_cols();
      if (reg_cols < 1) return 1;
      if (reg_cols > MAX_COLS) return MAX_COLS;
      return 32'(reg_cols);
   endfunction

   function automatic int unsigned span_rows();
      if (reg_rows < 2) return 2;
      if (reg_rows > MAX_ROWS) return MAX_ROWS;
      return 32'(reg_rows);
   endfunction

   function automatic logic [15:0] blank_cell();
      return {reg_colour, CH_SPACE};
   endfunction

   task automatic reset_model();
      foreach (cells[i]) cells[i] = {RESET_ATTR, CH_SPACE};
      col_q      = 0;
      row_q      = 0;
      scrolls    = '0;
      reg_cols   = RESET_COLS;
      reg_rows   = RESET_ROWS;
      reg_colour = RESET_ATTR;
      reg_cursor = 1'b1;
      cursor_results.delete();
      n_fail   = 0;
      n_req    = 0;
      n_rsp    = 0;
      n_scroll = 0;
   endtask

   task automatic scroll_screen(input int unsigned nc, input int unsigned nr);
      for (int j = 0; j + 1 < nr; j++)
         for (int i = 0; i < nc; i++)
            cells[j * nc + i] = cells[(j + 1) * nc + i];
      for (int i = 0; i < nc; i++)
         cells[(nr - 1) * nc + i] = blank_cell();
      col_q   = 0;
      row_q   = nr - 1;
      scrolls = scrolls + 16'd1;
      n_scroll++;
   endtask

   task automatic new_line(input int unsigned nc, input int unsigned nr);
      if (row_q >= nr - 1) begin
         scroll_screen(nc, nr);
      end else begin
         col_q = 0;
         row_q++;
      end
   endtask

   task automatic put_byte(input logic [7:0] c, output bit moved);
      int unsigned nc;
      int unsigned nr;
      nc = span_cols();
      nr = span_rows();
      moved = 1'b0;
      // deferred wrap happens first, whatever the byte
      if (col_q >= nc) begin
         new_line(nc, nr);
         moved = 1'b1;
      end
      if (c == CH_LF) begin
         new_line(nc, nr);
         moved = 1'b1;
      end else if (c == CH_NUL || c == CH_CR) begin
      end else if (c == CH_BS) begin
         if (col_q != 0 || row_q != 0) begin
            if (col_q == 0) begin
               row_q--;
               col_q = nc - 1;
            end else begin
               col_q--;
            end
            cells[row_q * nc + col_q] = blank_cell();
            moved = 1'b1;
         end
      end else begin
         cells[row_q * nc + col_q] = {reg_colour, c};
         col_q++;
         moved = 1'b1;
      end
   endtask

   task automatic push_result(input bit moved, input logic [7:0] ch, input logic [7:0] at,
                              input bit final_one);
      console_rsp_type r;
      int unsigned     lin;
      lin     = row_q * span_cols() + col_q;
      r.col   = col_q[6:0];
      r.row   = row_q[4:0];
      r.idx   = lin[10:0];
      r.wr    = moved && reg_cursor;
      r.lines = scrolls;
      r.chr   = ch;
      r.attr  = at;
      r.last  = final_one;
      cursor_results.push_back(r);
   endtask

   task automatic predict_request(input logic [1:0] kind, input logic [7:0] c,
                                  input logic [10:0] a);
      int unsigned nc;
      int unsigned nr;
      bit          moved;
      logic [15:0] v;
      nc = span_cols();
      nr = span_rows();
      // pull the cursor back inside a shrunk geometry, not counted as a move
      if (col_q > nc) col_q = nc;
      if (row_q > nr - 1) row_q = nr - 1;
      case (kind)
         REQ_PUT: begin
            if (c == CH_TAB) begin
               for (int k = 0; k < 4; k++) begin
                  put_byte(CH_SPACE, moved);
                  push_result(moved, 8'h00, 8'h00, k == 3);
               end
            end else begin
               put_byte(c, moved);
               push_result(moved, 8'h00, 8'h00, 1'b1);
            end
         end
         REQ_CLEAR: begin
            foreach (cells[i]) cells[i] = blank_cell();
            col_q   = 0;
            row_q   = 0;
            scrolls = '0;
            push_result(1'b1, 8'h00, 8'h00, 1'b1);
         end
         REQ_READ: begin
            v = (a < NCELLS) ? cells[a] : 16'h0000;
            push_result(1'b0, v[7:0], v[15:8], 1'b1);
         end
         default: push_result(1'b0, 8'h00, 8'h00, 1'b1);
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_model();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tlast, rsp_tdata};
            n_rsp++;
            if (cursor_results.size() == 0) begin
               n_fail++;
               if (n_fail <= 10)
                  $display("result transfer %0d with nothing expected: col %0d row %0d",
                           n_rsp, got.col, got.row);
            end else begin
               want = cursor_results.pop_front();
               if (got !== want) begin
                  n_fail++;
                  if (n_fail <= 10) begin
                     $display("result transfer %0d mismatch", n_rsp);
                     $display("  expected col %0d row %0d index %0d write %0b lines %0d",
                              want.col, want.row, want.idx, want.wr, want.lines,
                              " char %02h attr %02h last %0b", want.chr, want.attr, want.last);
                     $display("  actual   col %0d row %0d index %0d write %0b lines %0d",
                              got.col, got.row, got.idx, got.wr, got.lines,
                              " char %02h attr %02h last %0b", got.chr, got.attr, got.last);
                  end
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_COLUMNS: reg_cols   = csr_wdata[6:0];
               CSR_ROWS:    reg_rows   = csr_wdata[4:0];
               CSR_COLOUR:  reg_colour = csr_wdata;
               CSR_CURSOR:  reg_cursor = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            n_req++;
            predict_request(req_tuser, req_tdata[7:0], req_tdata[18:8]);
         end
      end
      mismatches    <= n_fail;
      outstanding   <= cursor_results.size();
      requests_seen <= n_req;
      results_seen  <= n_rsp;
      scrolls_seen  <= n_scroll;
   end

endmodule

// ----- dv/tb_text_console_character_engine_core.sv -----
`timescale 1ns / 1ps
// Testbench top for the text console engine: clock, reset, request and register stimulus,
// result back-pressure and verdict. Depends on tcce_pkg, the core and tcce_console_checker.

module tb_text_console_character_engine_core;
   import tcce_pkg::*;

   localparam logic [1:0] REQ_UNUSED  = 2'd3;
   localparam int         STALL_LIMIT = 20000;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = REQ_PUT;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_COLUMNS;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int mismatches;
   int outstanding;
   int requests_seen;
   int results_seen;
   int scrolls_seen;
   int settings_used = 0;
   int vis_cells     = NCELLS;
   bit steady        = 1'b0;

   text_console_character_engine_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   tcce_console_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .requests_seen (requests_seen),
      .results_seen  (results_seen),
      .scrolls_seen  (scrolls_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 20);
   end

   // request transfer; valid stays high into the next call unless an idle cycle is drawn
   task automatic send(input logic [1:0] kind, input logic [7:0] ch, input logic [10:0] addr);
      while (!steady && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'd0, addr, ch};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || !req_tready);
   endtask

   task automatic set_regs(input logic [6:0] cols, input logic [4:0] rows,
                           input logic [7:0] colour, input logic cursor_on);
      int ec;
      int er;
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_COLUMNS;
      csr_wdata <= {1'b0, cols};
      @(posedge clock);
      csr_index <= CSR_ROWS;
      csr_wdata <= {3'b000, rows};
      @(posedge clock);
      csr_index <= CSR_COLOUR;
      csr_wdata <= colour;
      @(posedge clock);
      csr_index <= CSR_CURSOR;
      csr_wdata <= {7'd0, cursor_on};
      @(posedge clock);
      csr_we <= 1'b0;
      ec = (int'(cols) < 1) ? 1 : (int'(cols) > MAX_COLS) ? MAX_COLS : int'(cols);
      er = (int'(rows) < 2) ? 2 : (int'(rows) > MAX_ROWS) ? MAX_ROWS : int'(rows);
      vis_cells = ec * er;
      settings_used++;
   endtask

   task automatic random_item();
      int          sel;
      logic [7:0]  ch;
      logic [10:0] addr;
      sel  = int'($urandom_range(0, 99));
      ch   = 8'($urandom_range(0, 255));
      addr = 11'($urandom_range(0, 2047));
      if (sel < 70) begin
         case ($urandom_range(0, 9))
            0: ch = CH_LF;
            1: ch = CH_BS;
            2: ch = CH_TAB;
            3: ch = ($urandom_range(0, 1) != 0) ? CH_CR : CH_NUL;
            default: ;
         endcase
         send(REQ_PUT, ch, addr);
      end else if (sel < 82) begin
         send(REQ_READ, ch, 11'($urandom_range(0, vis_cells - 1)));
      end else if (sel < 90) begin
         send(REQ_READ, ch, addr);
      end else if (sel < 95) begin
         send(REQ_CLEAR, ch, addr);
      end else begin
         send(REQ_UNUSED, ch, addr);
      end
   endtask

   initial begin : stimulus
      logic [6:0] cols_v;
      logic [4:0] rows_v;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: reads of the initial store, controls, tab, erase, clear
      send(REQ_READ, 8'h00, 11'd0);
      send(REQ_READ, 8'h00, 11'd1999);
      send(REQ_READ, 8'hFF, 11'd2047);
      send(REQ_PUT, 8'h48, 11'd0);
      send(REQ_PUT, 8'hFF, 11'd0);
      send(REQ_PUT, CH_NUL, 11'd0);
      send(REQ_PUT, CH_CR, 11'd0);
      send(REQ_PUT, CH_TAB, 11'd0);
      send(REQ_PUT, CH_BS, 11'd0);
      send(REQ_READ, 8'h00, 11'd5);
      send(REQ_UNUSED, 8'h41, 11'd3);
      send(REQ_PUT, CH_LF, 11'd0);
      send(REQ_PUT, CH_BS, 11'd0);
      send(REQ_READ, 8'h00, 11'd79);
      send(REQ_CLEAR, 8'h00, 11'd0);
      send(REQ_PUT, CH_BS, 11'd0);
      send(REQ_PUT, CH_LF, 11'd0);
      send(REQ_PUT, CH_LF, 11'd0);
      send(REQ_PUT, CH_LF, 11'd0);
      send(REQ_PUT, 8'h7A, 11'd0);

      // shrink with the cursor outside; wrap and newline on the last row scroll
      set_regs(7'd3, 5'd2, 8'hFF, 1'b0);
      send(REQ_PUT, 8'h61, 11'd0);
      send(REQ_PUT, 8'h62, 11'd0);
      send(REQ_PUT, 8'h63, 11'd0);
      send(REQ_PUT, CH_LF, 11'd0);
      send(REQ_PUT, CH_BS, 11'd0);
      send(REQ_READ, 8'h00, 11'd2);

      // out-of-range registers saturate
      set_regs(7'd0, 5'd1, 8'h00, 1'b1);
      send(REQ_PUT, 8'h78, 11'd0);
      send(REQ_PUT, 8'h79, 11'd0);
      send(REQ_PUT, 8'h71, 11'd0);
      send(REQ_PUT, CH_TAB, 11'd0);
      set_regs(7'd127, 5'd31, 8'hA5, 1'b1);
      send(REQ_PUT, 8'h6B, 11'd0);
      send(REQ_READ, 8'h00, 11'd1);

      for (int p = 0; p < 6; p++) begin
         case ($urandom_range(0, 9))
            0: cols_v = 7'd0;
            1: cols_v = 7'd1;
            2: cols_v = 7'd127;
            3: cols_v = 7'd80;
            default: cols_v = 7'($urandom_range(2, 8));
         endcase
         case ($urandom_range(0, 9))
            0: rows_v = 5'd0;
            1: rows_v = 5'd1;
            2: rows_v = 5'd31;
            3: rows_v = 5'd25;
            default: rows_v = 5'($urandom_range(2, 4));
         endcase
         set_regs(cols_v, rows_v, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         steady <= (p == 2);
         repeat (13) random_item();
      end

      wait_idle();
      repeat (64) @(posedge clock);
      $display("Run covered %0d requests, %0d result transfers and %0d predicted scrolls",
               requests_seen, results_seen, scrolls_seen);
      $display("over %0d register settings, from one saturated column to the full screen",
               settings_used);
      if (mismatches == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      @(negedge reset);
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("no transfer for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
